// ===== rtl/mwssl_pkg.sv =====
// Shared constants for the mecanum wheel speed slew limiter.
package mwssl_pkg;

  localparam int unsigned NUM_WHEELS  = 4;
  localparam int unsigned IN_W        = 16;
  localparam int unsigned RADIUS_W    = 15;
  localparam int unsigned PROD_W      = 32;
  localparam int unsigned STEP_W      = 16;
  localparam int unsigned OUT_W       = 32;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [STEP_W-1:0] STEP_RESET = 16'd3000;

  // Wheel order in the result word.
  localparam int unsigned WHEEL_UPPER_RIGHT = 0;
  localparam int unsigned WHEEL_LOWER_LEFT  = 1;
  localparam int unsigned WHEEL_LOWER_RIGHT = 2;
  localparam int unsigned WHEEL_UPPER_LEFT  = 3;

endpackage

// ===== rtl/mwssl_cmd_if.sv =====
// Command channel: body velocity words with valid/ready handshake.
interface mwssl_cmd_if import mwssl_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [IN_W-1:0]     speed_y;
  logic signed [IN_W-1:0]     speed_x;
  logic signed [IN_W-1:0]     turn_rate;
  logic        [RADIUS_W-1:0] turn_radius;

  modport source (output valid, speed_y, speed_x, turn_rate, turn_radius, input ready);
  modport sink   (input valid, speed_y, speed_x, turn_rate, turn_radius, output ready);
endinterface

// ===== rtl/mwssl_wheel_if.sv =====
// Result channel: four limited wheel speeds with valid/ready handshake.
interface mwssl_wheel_if import mwssl_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] wheel_upper_right;
  logic signed [OUT_W-1:0] wheel_lower_left;
  logic signed [OUT_W-1:0] wheel_lower_right;
  logic signed [OUT_W-1:0] wheel_upper_left;

  modport source (output valid, wheel_upper_right, wheel_lower_left, wheel_lower_right,
                  wheel_upper_left, input ready);
  modport sink   (input valid, wheel_upper_right, wheel_lower_left, wheel_lower_right,
                  wheel_upper_left, output ready);
endinterface

// ===== rtl/mwssl_front.sv =====
// Front end: accept commands, register the turn product, form saturated wheel targets.
module mwssl_front import mwssl_pkg::*; #(
  parameter int unsigned SPEED_WIDTH = 32
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  mwssl_cmd_if.sink                                     cmd_i,
  output logic                                          push_o,
  output logic signed [NUM_WHEELS-1:0][SPEED_WIDTH-1:0] target_o,
  input  logic                                          full_i
);

  localparam int unsigned EXT_W = ((SPEED_WIDTH > PROD_W) ? SPEED_WIDTH : PROD_W) + 2;

  localparam logic signed [EXT_W-1:0] SAT_HI =
    EXT_W'(signed'({1'b0, {(SPEED_WIDTH-1){1'b1}}}));
  localparam logic signed [EXT_W-1:0] SAT_LO = ~SAT_HI;

  logic                     s1_valid_q, s1_valid_d;
  logic signed [IN_W-1:0]   vy_q, vx_q;
  logic signed [PROD_W-1:0] turn_q;
  logic                     advance;

  logic signed [EXT_W-1:0] vy_ext, vx_ext, turn_ext;
  logic signed [NUM_WHEELS-1:0][EXT_W-1:0] sum;

  // Stage advances whenever its word can move into the queue.
  assign advance     = !s1_valid_q || !full_i;
  assign cmd_i.ready = advance;
  assign push_o      = s1_valid_q && !full_i;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (advance) begin
      s1_valid_d = cmd_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && cmd_i.valid) begin
      vy_q   <= cmd_i.speed_y;
      vx_q   <= cmd_i.speed_x;
      turn_q <= PROD_W'(cmd_i.turn_rate) * PROD_W'(signed'({1'b0, cmd_i.turn_radius}));
    end
  end

  assign vy_ext   = EXT_W'(vy_q);
  assign vx_ext   = EXT_W'(vx_q);
  assign turn_ext = EXT_W'(turn_q);

  assign sum[WHEEL_UPPER_RIGHT] =  vy_ext + vx_ext + turn_ext;
  assign sum[WHEEL_LOWER_LEFT]  = -vy_ext - vx_ext + turn_ext;
  assign sum[WHEEL_LOWER_RIGHT] =  vy_ext - vx_ext - turn_ext;
  assign sum[WHEEL_UPPER_LEFT]  = -vy_ext + vx_ext - turn_ext;

  // Clamp each target to the signed speed range.
  always_comb begin
    for (int i = 0; i < NUM_WHEELS; i++) begin
      if ($signed(sum[i]) > SAT_HI) begin
        target_o[i] = SAT_HI[SPEED_WIDTH-1:0];
      end else if ($signed(sum[i]) < SAT_LO) begin
        target_o[i] = SAT_LO[SPEED_WIDTH-1:0];
      end else begin
        target_o[i] = sum[i][SPEED_WIDTH-1:0];
      end
    end
  end

endmodule

// ===== rtl/mwssl_queue.sv =====
// Short queue of target words between the front and back ends.
module mwssl_queue import mwssl_pkg::*; #(
  parameter int unsigned DATA_W = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output logic [DATA_W-1:0] head_o
);

  logic [QUEUE_DEPTH-1:0][DATA_W-1:0] entry_q;
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   count_q, count_d;

  assign full_o  = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/mwssl_back.sv =====
// Back end: slew-limit each target against the wheel's last speed and hold the result word.
module mwssl_back import mwssl_pkg::*; #(
  parameter int unsigned SPEED_WIDTH = 32
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          cfg_we_i,
  input  logic [STEP_W-1:0]                             cfg_wdata_i,
  input  logic                                          empty_i,
  input  logic signed [NUM_WHEELS-1:0][SPEED_WIDTH-1:0] target_i,
  output logic                                          pop_o,
  mwssl_wheel_if.source                                 wheel_o
);

  localparam int unsigned DIFF_W = SPEED_WIDTH + 1;
  localparam int unsigned WIDE_W = (SPEED_WIDTH > OUT_W) ? SPEED_WIDTH : OUT_W;

  logic [STEP_W-1:0] max_step_q;
  logic              out_valid_q, out_valid_d;
  logic signed [NUM_WHEELS-1:0][SPEED_WIDTH-1:0] last_q, last_d;
  logic signed [NUM_WHEELS-1:0][WIDE_W-1:0]      wide;

  logic signed [DIFF_W-1:0] step_ext;
  logic signed [DIFF_W-1:0] cur_ext, tgt_ext, diff, up, dn;

  assign step_ext = signed'(DIFF_W'(max_step_q));

  // Take the head word when the output register is free or being drained.
  assign pop_o = !empty_i && (!out_valid_q || wheel_o.ready);

  always_comb begin
    for (int i = 0; i < NUM_WHEELS; i++) begin
      cur_ext = DIFF_W'($signed(last_q[i]));
      tgt_ext = DIFF_W'($signed(target_i[i]));
      diff    = tgt_ext - cur_ext;
      up      = cur_ext + step_ext;
      dn      = cur_ext - step_ext;
      if (diff > step_ext) begin
        last_d[i] = up[SPEED_WIDTH-1:0];
      end else if (diff < -step_ext) begin
        last_d[i] = dn[SPEED_WIDTH-1:0];
      end else begin
        last_d[i] = target_i[i];
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (wheel_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_step_q  <= STEP_RESET;
      out_valid_q <= 1'b0;
      last_q      <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        max_step_q <= cfg_wdata_i;
      end
      if (pop_o) begin
        last_q <= last_d;
      end
    end
  end

  // The last speeds double as the output word.
  always_comb begin
    for (int i = 0; i < NUM_WHEELS; i++) begin
      wide[i] = WIDE_W'($signed(last_q[i]));
    end
  end

  assign wheel_o.valid             = out_valid_q;
  assign wheel_o.wheel_upper_right = wide[WHEEL_UPPER_RIGHT][OUT_W-1:0];
  assign wheel_o.wheel_lower_left  = wide[WHEEL_LOWER_LEFT][OUT_W-1:0];
  assign wheel_o.wheel_lower_right = wide[WHEEL_LOWER_RIGHT][OUT_W-1:0];
  assign wheel_o.wheel_upper_left  = wide[WHEEL_UPPER_LEFT][OUT_W-1:0];

endmodule

// ===== rtl/mecanum_wheel_speed_slew_limit_top.sv =====
// Top level of the mecanum wheel speed slew limiter.
// Takes one command word per cycle while wheel_o.ready stays high and returns one word of
// four wheel speeds per command, in command order. An accepted command loads the turn-rate
// times radius multiplier register, then its target is written into the four-entry queue,
// and then it loads the slew-limited speed register, which also serves as the output word.
// Sustained rate is one command per cycle while wheel_o.ready stays high, set by the
// per-wheel compare-and-step loop that updates the last speeds for each word taken from
// the queue. max_step resets to 3000 and is written through cfg_we_i / cfg_wdata_i.
module mecanum_wheel_speed_slew_limit_top import mwssl_pkg::*; #(
  parameter int unsigned SPEED_WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [STEP_W-1:0] cfg_wdata_i,
  mwssl_cmd_if.sink         cmd_i,
  mwssl_wheel_if.source     wheel_o
);

  localparam int unsigned WORD_W = NUM_WHEELS * SPEED_WIDTH;

  logic                                          push, full, pop, empty;
  logic signed [NUM_WHEELS-1:0][SPEED_WIDTH-1:0] target, head;
  logic [WORD_W-1:0]                             head_word;

  mwssl_front #(.SPEED_WIDTH(SPEED_WIDTH)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd_i),
    .push_o   (push),
    .target_o (target),
    .full_i   (full)
  );

  mwssl_queue #(.DATA_W(WORD_W)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (target),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head_word)
  );

  assign head = head_word;

  mwssl_back #(.SPEED_WIDTH(SPEED_WIDTH)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .empty_i     (empty),
    .target_i    (head),
    .pop_o       (pop),
    .wheel_o     (wheel_o)
  );

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the mecanum wheel speed slew limiter top level.
module testbench;
  import mwssl_pkg::*;

  localparam int SPEED_WIDTH  = 32;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int STALL_CYCLES = 300;
  localparam int LATENCY      = 2;
  localparam int SEGMENTS     = 7;
  localparam int SEG_ITEMS    = 100;

  typedef struct packed {
    logic signed [IN_W-1:0]   speed_y;
    logic signed [IN_W-1:0]   speed_x;
    logic signed [IN_W-1:0]   turn_rate;
    logic        [RADIUS_W-1:0] turn_radius;
  } cmd_word_t;

  typedef logic [NUM_WHEELS-1:0][OUT_W-1:0] wheel_set_t;

  class wheel_scoreboard;
    longint            last_speed[NUM_WHEELS];
    logic [STEP_W-1:0] max_step;
    wheel_set_t        wheel_q[$];
    int                mismatches;
    string             wheel_name[NUM_WHEELS] =
      '{"upper_right", "lower_left", "lower_right", "upper_left"};

    function new();
      foreach (last_speed[i]) last_speed[i] = 0;
      max_step   = STEP_RESET;
      mismatches = 0;
    endfunction

    function void set_max_step(logic [STEP_W-1:0] v);
      max_step = v;
    endfunction

    function int pending();
      return wheel_q.size();
    endfunction

    function longint saturate_speed(longint v);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (SPEED_WIDTH - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    function longint slew_toward(longint cur, longint tgt, longint lim);
      longint diff;
      diff = tgt - cur;
      if (diff > lim) return cur + lim;
      if (diff < -lim) return cur - lim;
      return tgt;
    endfunction

    // Predict the wheel word for an accepted command and advance the last speeds.
    function void note_command(cmd_word_t c);
      longint     vy;
      longint     vx;
      longint     turn;
      longint     radius;
      longint     tgt[NUM_WHEELS];
      wheel_set_t w;
      vy     = longint'($signed(c.speed_y));
      vx     = longint'($signed(c.speed_x));
      radius = c.turn_radius;
      turn   = longint'($signed(c.turn_rate)) * radius;
      tgt[WHEEL_UPPER_RIGHT] = saturate_speed(vy + vx + turn);
      tgt[WHEEL_LOWER_LEFT]  = saturate_speed(-vy - vx + turn);
      tgt[WHEEL_LOWER_RIGHT] = saturate_speed(vy - vx - turn);
      tgt[WHEEL_UPPER_LEFT]  = saturate_speed(-vy + vx - turn);
      for (int i = 0; i < NUM_WHEELS; i++) begin
        last_speed[i] = slew_toward(last_speed[i], tgt[i], longint'(max_step));
        w[i] = last_speed[i][OUT_W-1:0];
      end
      wheel_q.push_back(w);
    endfunction

    function void check_wheels(wheel_set_t got);
      wheel_set_t exp;
      if (wheel_q.size() == 0) begin
        $display("%0t: wheel word with no command pending: %h", $time, got);
        mismatches++;
        return;
      end
      exp = wheel_q.pop_front();
      for (int i = 0; i < NUM_WHEELS; i++) begin
        if (got[i] !== exp[i]) begin
          $display("%0t: wheel %s expected %0d actual %0d", $time, wheel_name[i],
                   $signed(exp[i]), $signed(got[i]));
          mismatches++;
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [STEP_W-1:0] cfg_wdata_i;

  mwssl_cmd_if   cmd_bus();
  mwssl_wheel_if wheel_bus();

  wheel_scoreboard sb = new();

  int send_idle_pct;
  int recv_idle_pct;
  bit stall_toggle;
  int cycle_count;

  mecanum_wheel_speed_slew_limit_top #(
    .SPEED_WIDTH(SPEED_WIDTH)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cmd_i      (cmd_bus),
    .wheel_o    (wheel_bus)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver: check each accepted word, then pick ready for the next cycle.
  initial begin
    wheel_set_t got;
    int         stall_left;
    bit         stall_ack;
    stall_left      = 0;
    stall_ack       = 1'b0;
    wheel_bus.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (wheel_bus.valid && wheel_bus.ready) begin
        got[WHEEL_UPPER_RIGHT] = wheel_bus.wheel_upper_right;
        got[WHEEL_LOWER_LEFT]  = wheel_bus.wheel_lower_left;
        got[WHEEL_LOWER_RIGHT] = wheel_bus.wheel_lower_right;
        got[WHEEL_UPPER_LEFT]  = wheel_bus.wheel_upper_left;
        sb.check_wheels(got);
      end
      if (stall_toggle != stall_ack) begin
        stall_ack  = stall_toggle;
        stall_left = STALL_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        wheel_bus.ready <= 1'b0;
      end else begin
        wheel_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_command(input cmd_word_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_bus.valid       <= 1'b1;
    cmd_bus.speed_y     <= c.speed_y;
    cmd_bus.speed_x     <= c.speed_x;
    cmd_bus.turn_rate   <= c.turn_rate;
    cmd_bus.turn_radius <= c.turn_radius;
    do @(posedge clk_i); while (!cmd_bus.ready);
    sb.note_command(c);
  endtask

  task automatic send_fields(input int y, input int x, input int rate, input int radius);
    cmd_word_t c;
    c.speed_y     = y[IN_W-1:0];
    c.speed_x     = x[IN_W-1:0];
    c.turn_rate   = rate[IN_W-1:0];
    c.turn_radius = radius[RADIUS_W-1:0];
    send_command(c);
  endtask

  // Drop valid and hold until every predicted word has come back.
  task automatic wait_drained();
    cmd_bus.valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic write_max_step(input logic [STEP_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    sb.set_max_step(v);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [IN_W-1:0] near_zero(input int span);
    int v;
    v = int'($urandom_range(2 * span)) - span;
    return v[IN_W-1:0];
  endfunction

  function automatic logic [IN_W-1:0] pick_extreme();
    case ($urandom_range(3))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      default: return 16'hffff;
    endcase
  endfunction

  function automatic cmd_word_t random_command();
    cmd_word_t c;
    int        kind;
    kind = $urandom_range(9);
    if (kind <= 3) begin
      c.speed_y     = IN_W'($urandom_range(65535));
      c.speed_x     = IN_W'($urandom_range(65535));
      c.turn_rate   = IN_W'($urandom_range(65535));
      c.turn_radius = RADIUS_W'($urandom_range(32767));
    end else if (kind <= 7) begin
      // targets stay close to the last speeds so the limit and pass-through both fire
      c.speed_y     = near_zero(4000);
      c.speed_x     = near_zero(4000);
      c.turn_rate   = near_zero(200);
      c.turn_radius = RADIUS_W'($urandom_range(15));
    end else if (kind == 8) begin
      c.speed_y     = IN_W'($urandom_range(65535));
      c.speed_x     = IN_W'($urandom_range(65535));
      c.turn_rate   = IN_W'($urandom_range(65535));
      c.turn_radius = '0;
    end else begin
      c.speed_y     = pick_extreme();
      c.speed_x     = pick_extreme();
      c.turn_rate   = pick_extreme();
      c.turn_radius = $urandom_range(1) ? 15'h7fff : 15'h0000;
    end
    return c;
  endfunction

  initial begin
    int                seg;
    int                n;
    logic [STEP_W-1:0] step_val;
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_wdata_i         = '0;
    cmd_bus.valid       = 1'b0;
    cmd_bus.speed_y     = '0;
    cmd_bus.speed_x     = '0;
    cmd_bus.turn_rate   = '0;
    cmd_bus.turn_radius = '0;
    send_idle_pct       = 29;
    recv_idle_pct       = 82;
    stall_toggle        = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset step of 3000: exact-distance move first, then extremes.
    send_fields(3000, 0, 0, 0);
    send_fields(3001, 0, 0, 0);
    send_fields(-32768, -32768, -32768, 32767);
    send_fields(32767, 32767, 32767, 32767);
    send_fields(32767, -32768, -32768, 32767);
    send_fields(-32768, 32767, 32767, 0);
    send_fields(0, 0, 0, 0);
    wait_drained();

    // Zero step: speeds must hold.
    write_max_step('0);
    send_fields(32767, 32767, 32767, 32767);
    send_fields(-32768, -32768, -32768, 32767);
    send_fields(1, -1, 1, 1);
    wait_drained();

    write_max_step(16'hffff);
    send_fields(32767, 32767, 32767, 32767);
    send_fields(-32768, -32768, -32768, 32767);
    send_fields(-32768, 32767, -32768, 32767);
    send_fields(0, 0, 0, 0);
    send_fields(1, 2, 3, 4);
    send_fields(-1, -1, -1, 1);
    send_fields(0, 0, 0, 0);
    wait_drained();

    for (seg = 0; seg < SEGMENTS; seg++) begin
      case (seg)
        0:       step_val = 16'd1;
        1:       step_val = 16'hffff;
        2:       step_val = 16'($urandom_range(65535));
        3:       step_val = '0;
        4:       step_val = 16'($urandom_range(50, 1));
        5:       step_val = STEP_RESET;
        default: step_val = 16'($urandom_range(8000, 100));
      endcase
      if (seg == 3) begin
        send_idle_pct = 82;
        recv_idle_pct <= 29;
      end else if (seg == 5) begin
        send_idle_pct = 0;
        recv_idle_pct <= 0;
      end
      write_max_step(step_val);
      for (n = 0; n < SEG_ITEMS; n++) begin
        // long receiver hold-off while commands keep coming
        if ((seg == 3 || seg == 5) && n == 10) stall_toggle <= ~stall_toggle;
        send_command(random_command());
      end
      wait_drained();
    end

    repeat (LATENCY + 8) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
